### design/crpm_pkg.sv
// Shared types and constants for the concentric ring pixel mask.
`default_nettype none
package crpm_pkg;

  // Field widths fixed by the interface
  localparam int DIM_W   = 13;
  localparam int COORD_W = 12;
  localparam int PIX_W   = 8;

  // Largest frame dimension honored; larger sizes are clamped to it
  localparam int MAX_DIM = 4096;

  // Mapping constants: coordinates span -HALF_SPAN..HALF_SPAN
  localparam int SPAN       = 20;
  localparam int HALF_SPAN  = 10;
  localparam int RING_COUNT = 15;
  localparam int MAG_LIMIT  = 16;

  // Configuration register indexes
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(512);

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pix_t;

  // Treat a zero size as one and an oversize value as the largest size
  function automatic logic [DIM_W-1:0] clamp_size(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end
    if (32'(v) > 32'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return v;
  endfunction

endpackage
`default_nettype wire

### design/concentric_ring_pixel_mask.sv
// Top level of the concentric ring pixel mask: divider, distance and mask pipeline.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------------
//  in_     | input     | in_valid/in_ready  | column, line_index, pixel_blue/green/red
//  out_    | output    | out_valid/out_ready| out_blue/green/red, out_masked
//  cfg_    | input     | cfg_we             | cfg_index selects width or height, cfg_wdata
//
// One item enters per cycle while the output side accepts results (out_ready); the depth is
// set by the two restoring dividers that resolve four quotient bits per stage, followed by
// magnitude, square, sum and ring compare stages.
// rst_n is synchronous: it clears all stage valid bits and loads both sizes with 512.
// Each stage holds while the stage after it is full and stalled; empty stages refill,
// so bubbles close up and a waiting result never blocks input while space remains.
`default_nettype none
module concentric_ring_pixel_mask #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [crpm_pkg::DIM_W-1:0]    cfg_wdata,
  // input items
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [crpm_pkg::COORD_W-1:0]  in_column,
  input  wire logic [crpm_pkg::COORD_W-1:0]  in_line_index,
  input  wire logic [crpm_pkg::PIX_W-1:0]    in_pixel_blue,
  input  wire logic [crpm_pkg::PIX_W-1:0]    in_pixel_green,
  input  wire logic [crpm_pkg::PIX_W-1:0]    in_pixel_red,
  // result items
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [crpm_pkg::PIX_W-1:0]         out_blue,
  output logic [crpm_pkg::PIX_W-1:0]         out_green,
  output logic [crpm_pkg::PIX_W-1:0]         out_red,
  output logic                               out_masked
);
  import crpm_pkg::*;

  // Dividend is coord * 20 * 2^FRAC_BITS
  localparam int NUM_W      = COORD_W + 5 + FRAC_BITS;
  localparam int BPS        = 4;
  localparam int DIV_STAGES = (NUM_W + BPS - 1) / BPS;
  localparam int NP         = DIV_STAGES * BPS;
  localparam int NUM_STAGES = DIV_STAGES + 4;
  localparam int MAG_STG    = DIV_STAGES;
  localparam int SQ_STG     = DIV_STAGES + 1;
  localparam int SUM_STG    = DIV_STAGES + 2;
  localparam int OUT_STG    = DIV_STAGES + 3;
  // Saturated magnitude is at most 16 * 2^FRAC_BITS
  localparam int MW         = FRAC_BITS + 5;
  localparam int SQW        = 2 * MW;
  localparam int SUMW       = SQW + 1;

  localparam logic [NP-1:0] CENTRE    = NP'(HALF_SPAN) << FRAC_BITS;
  localparam logic [NP-1:0] MAG_SAT   = NP'(MAG_LIMIT) << FRAC_BITS;

  // Run BPS restoring division steps: returns {remainder, shifted work word}
  function automatic logic [DIM_W+NP-1:0] div_steps(
    input logic [DIM_W-1:0] rem,
    input logic [NP-1:0]    work,
    input logic [DIM_W-1:0] dvs
  );
    logic [DIM_W:0]   trial;
    logic [DIM_W-1:0] r;
    logic [NP-1:0]    w;
    r = rem;
    w = work;
    for (int s = 0; s < BPS; s++) begin
      trial = {r, w[NP-1]};
      if (trial >= {1'b0, dvs}) begin
        trial = trial - {1'b0, dvs};
        w     = {w[NP-2:0], 1'b1};
      end else begin
        w     = {w[NP-2:0], 1'b0};
      end
      r = trial[DIM_W-1:0];
    end
    return {r, w};
  endfunction

  // Configuration registers
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic [DIM_W-1:0] div_x;
  logic [DIM_W-1:0] div_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default:          width_r  <= width_r;
      endcase
    end
  end

  assign div_x = clamp_size(width_r);
  assign div_y = clamp_size(height_r);

  // Stage valid bits and ready chain
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES:0]   stage_rdy;
  pix_t                  pix_r [NUM_STAGES];
  pix_t                  pix_in;

  assign stage_rdy[NUM_STAGES] = out_ready;
  assign in_ready  = stage_rdy[0];
  assign out_valid = vld_r[OUT_STG];
  assign pix_in    = '{blue: in_pixel_blue, green: in_pixel_green, red: in_pixel_red};

  genvar g;
  generate
    for (g = 0; g < NUM_STAGES; g++) begin : g_ctl
      logic up_vld;
      if (g == 0) begin : g_first
        assign up_vld = in_valid;
      end else begin : g_rest
        assign up_vld = vld_r[g-1];
      end

      assign stage_rdy[g] = !vld_r[g] || stage_rdy[g+1];

      // Advance the valid bit when this stage can take a new item
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[g] <= 1'b0;
        end else if (stage_rdy[g]) begin
          vld_r[g] <= up_vld;
        end
      end
    end
  endgenerate

  // Carry the source pixel along all stages but the output stage
  generate
    for (g = 0; g < OUT_STG; g++) begin : g_pix
      always_ff @(posedge clk) begin
        if (stage_rdy[g]) begin
          pix_r[g] <= (g == 0) ? pix_in : pix_r[(g == 0) ? 0 : g - 1];
        end
      end
    end
  endgenerate

  // Dividend of each axis: coord * 20, scaled by 2^FRAC_BITS
  logic [NP-1:0] num_x;
  logic [NP-1:0] num_y;

  assign num_x = (NP'({in_column, 4'b0}) + NP'({in_column, 2'b0})) << FRAC_BITS;
  assign num_y = (NP'({in_line_index, 4'b0}) + NP'({in_line_index, 2'b0})) << FRAC_BITS;

  // Divider pipeline: four quotient bits per stage for each axis
  logic [DIM_W-1:0] rem_x_r  [DIV_STAGES];
  logic [DIM_W-1:0] rem_y_r  [DIV_STAGES];
  logic [NP-1:0]    work_x_r [DIV_STAGES];
  logic [NP-1:0]    work_y_r [DIV_STAGES];

  generate
    for (g = 0; g < DIV_STAGES; g++) begin : g_div
      logic [DIM_W-1:0]    rx_in;
      logic [DIM_W-1:0]    ry_in;
      logic [NP-1:0]       wx_in;
      logic [NP-1:0]       wy_in;
      logic [DIM_W+NP-1:0] x_nxt;
      logic [DIM_W+NP-1:0] y_nxt;

      if (g == 0) begin : g_first
        assign rx_in = '0;
        assign ry_in = '0;
        assign wx_in = num_x;
        assign wy_in = num_y;
      end else begin : g_rest
        assign rx_in = rem_x_r[g-1];
        assign ry_in = rem_y_r[g-1];
        assign wx_in = work_x_r[g-1];
        assign wy_in = work_y_r[g-1];
      end

      assign x_nxt = div_steps(rx_in, wx_in, div_x);
      assign y_nxt = div_steps(ry_in, wy_in, div_y);

      always_ff @(posedge clk) begin
        if (stage_rdy[g]) begin
          {rem_x_r[g], work_x_r[g]} <= x_nxt;
          {rem_y_r[g], work_y_r[g]} <= y_nxt;
        end
      end
    end
  endgenerate

  // Distance from centre, saturated
  logic [NP-1:0] quo_x;
  logic [NP-1:0] quo_y;
  logic [NP-1:0] abs_x;
  logic [NP-1:0] abs_y;
  logic [MW-1:0] mag_x_nxt;
  logic [MW-1:0] mag_y_nxt;
  logic [MW-1:0] mag_x_r;
  logic [MW-1:0] mag_y_r;

  assign quo_x     = work_x_r[DIV_STAGES-1];
  assign quo_y     = work_y_r[DIV_STAGES-1];
  assign abs_x     = (quo_x >= CENTRE) ? (quo_x - CENTRE) : (CENTRE - quo_x);
  assign abs_y     = (quo_y >= CENTRE) ? (quo_y - CENTRE) : (CENTRE - quo_y);
  assign mag_x_nxt = (abs_x > MAG_SAT) ? MAG_SAT[MW-1:0] : abs_x[MW-1:0];
  assign mag_y_nxt = (abs_y > MAG_SAT) ? MAG_SAT[MW-1:0] : abs_y[MW-1:0];

  always_ff @(posedge clk) begin
    if (stage_rdy[MAG_STG]) begin
      mag_x_r <= mag_x_nxt;
      mag_y_r <= mag_y_nxt;
    end
  end

  // Square each magnitude
  logic [SQW-1:0] sq_x_r;
  logic [SQW-1:0] sq_y_r;

  always_ff @(posedge clk) begin
    if (stage_rdy[SQ_STG]) begin
      sq_x_r <= SQW'(mag_x_r) * SQW'(mag_x_r);
      sq_y_r <= SQW'(mag_y_r) * SQW'(mag_y_r);
    end
  end

  // Add the squares
  logic [SUMW-1:0] d2_r;

  always_ff @(posedge clk) begin
    if (stage_rdy[SUM_STG]) begin
      d2_r <= SUMW'(sq_x_r) + SUMW'(sq_y_r);
    end
  end

  // Ring parity: thresholds are ordered, so the parity of the count is the XOR
  logic [RING_COUNT-1:0] ring_ge;
  logic                  masked_nxt;
  pix_t                  pix_out_nxt;
  logic                  masked_r;

  always_comb begin
    for (int k = 1; k <= RING_COUNT; k++) begin
      ring_ge[k-1] = (d2_r >= (SUMW'(k * k) << (2 * FRAC_BITS)));
    end
  end

  assign masked_nxt  = ^ring_ge;
  assign pix_out_nxt = masked_nxt ? pix_t'('0) : pix_r[SUM_STG];

  always_ff @(posedge clk) begin
    if (stage_rdy[OUT_STG]) begin
      masked_r        <= masked_nxt;
      pix_r[OUT_STG]  <= pix_out_nxt;
    end
  end

  assign out_blue   = pix_r[OUT_STG].blue;
  assign out_green  = pix_r[OUT_STG].green;
  assign out_red    = pix_r[OUT_STG].red;
  assign out_masked = masked_r;

  // Checks
  a_in_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0] |-> in_ready)
    else $error("input stalled with first stage empty");

  a_size_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (div_x != '0) && (div_y != '0) && (32'(div_x) <= 32'(MAX_DIM))
    && (32'(div_y) <= 32'(MAX_DIM)))
    else $error("clamped frame size out of range");

  a_mag_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SQ_STG - 1] |-> ((NP'(mag_x_r) <= MAG_SAT) && (NP'(mag_y_r) <= MAG_SAT)))
    else $error("distance magnitude above saturation limit");

  a_one_out_per_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ($countones(vld_r) + 1 >= $past($countones(vld_r))))
    else $error("more than one item left the pipeline in a cycle");

endmodule
`default_nettype wire
